// ----- rtl/smatch_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the stable matching engine.
`timescale 1ns / 1ps

package smatch_pkg;

    localparam int MAX_PEOPLE = 16;
    localparam int IDX_W      = 4;               // person / position / partner index
    localparam int CNT_W      = 5;               // counts that must reach MAX_PEOPLE
    localparam int MEM_DEPTH  = MAX_PEOPLE * MAX_PEOPLE;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_LOAD_MAN   = 2'd0,
        OP_LOAD_WOMAN = 2'd1,
        OP_RUN        = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_man;    // write a man's choice entry
        logic load_woman;  // write a woman's rank entry
        logic start;       // clear matching state, latch population
        logic search;      // pick lowest free man, read his next choice
        logic fetch;       // latch current holder and both ranks
        logic engage;      // pair current man with chosen woman
        logic displace;    // free the woman's previous man
        logic emit_load;   // load output register with next man
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic cand_found;     // some free man still has choices left
        logic w_invalid;      // chosen woman is outside the population
        logic w_free;         // chosen woman holds nobody
        logic suitor_better;  // woman ranks the suitor above her holder
        logic out_last;       // output register holds the final pair
    } t_status;

endpackage

// ----- rtl/smatch_ctrl.sv -----
// Sequencing state machine for loads, the proposal loop and the result stream.
`timescale 1ns / 1ps

module smatch_ctrl
    import smatch_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH,
        S_COMPARE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   in_xfer;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign in_xfer = i_valid && o_ready;

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = r_valid;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_op)
                        OP_LOAD_MAN:   o_cmd.load_man   = 1'b1;
                        OP_LOAD_WOMAN: o_cmd.load_woman = 1'b1;
                        OP_RUN: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_status.cand_found) begin
                    o_cmd.search = 1'b1;
                    n_state      = S_FETCH;
                end else begin
                    o_cmd.emit_load = 1'b1;
                    n_valid         = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (i_status.w_invalid) begin
                    n_state = S_SEARCH;
                end else if (i_status.w_free) begin
                    o_cmd.engage = 1'b1;
                    n_state      = S_SEARCH;
                end else begin
                    n_state = S_COMPARE;
                end
            end
            S_COMPARE: begin
                if (i_status.suitor_better) begin
                    o_cmd.engage   = 1'b1;
                    o_cmd.displace = 1'b1;
                end
                n_state = S_SEARCH;
            end
            S_EMIT: begin
                if (i_ready) begin
                    if (i_status.out_last) begin
                        n_valid = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_load = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_valid = 1'b0;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

// ----- rtl/smatch_dp.sv -----
// Preference memories, engagement state and output register for the matching engine.
`timescale 1ns / 1ps

module smatch_dp
    import smatch_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic [IDX_W-1:0] i_person,
    input  logic [IDX_W-1:0] i_position,
    input  logic [IDX_W-1:0] i_partner,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic [IDX_W-1:0] o_man_index,
    output logic [IDX_W-1:0] o_woman_index,
    output logic             o_last
);

    // Configuration and run population
    logic [CNT_W-1:0] r_people;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] pop_clamped;

    // Preference memories
    logic [IDX_W-1:0] r_man_mem  [MEM_DEPTH];
    logic [IDX_W-1:0] r_rank_mem [MEM_DEPTH];

    // Matching state
    logic [CNT_W-1:0] r_next      [MAX_PEOPLE];
    logic [IDX_W-1:0] r_man_wife  [MAX_PEOPLE];
    logic [IDX_W-1:0] r_woman_man [MAX_PEOPLE];
    logic [MAX_PEOPLE-1:0] r_man_free;
    logic [MAX_PEOPLE-1:0] r_woman_taken;

    // Proposal registers
    logic [IDX_W-1:0] r_m;
    logic [IDX_W-1:0] r_choice;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_rank_suitor;
    logic [IDX_W-1:0] r_rank_cur;

    // Output register and index
    logic [IDX_W-1:0] r_emit_idx;
    logic [IDX_W-1:0] r_out_man;
    logic [IDX_W-1:0] r_out_woman;
    logic             r_out_last;

    logic [MAX_PEOPLE-1:0] cand;
    logic [IDX_W-1:0]      cand_idx;
    logic [IDX_W-1:0]      cur_holder;

    // Clamp population to 1..MAX_PEOPLE
    always_comb begin
        if (r_people == '0)
            pop_clamped = CNT_W'(1);
        else if (r_people > CNT_W'(MAX_PEOPLE))
            pop_clamped = CNT_W'(MAX_PEOPLE);
        else
            pop_clamped = r_people;
    end

    // Find the lowest free man with choices left
    always_comb begin
        cand_idx = '0;
        for (int i = 0; i < MAX_PEOPLE; i++) begin
            cand[i] = r_man_free[i] && (r_next[i] < r_n) && (CNT_W'(i) < r_n);
        end
        for (int i = MAX_PEOPLE - 1; i >= 0; i--) begin
            if (cand[i])
                cand_idx = IDX_W'(i);
        end
    end

    assign cur_holder = r_woman_man[r_choice];

    always_comb begin
        o_status.cand_found    = |cand;
        o_status.w_invalid     = ({1'b0, r_choice} >= r_n);
        o_status.w_free        = !r_woman_taken[r_choice];
        o_status.suitor_better = (r_rank_suitor < r_rank_cur);
        o_status.out_last      = r_out_last;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_people <= CNT_W'(MAX_PEOPLE);
        else if (i_cfg_we)
            r_people <= i_cfg_wdata;
    end

    // Man choice memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_man)
            r_man_mem[{i_person, i_position}] <= i_partner;
        if (i_cmd.search)
            r_choice <= r_man_mem[{cand_idx, r_next[cand_idx][IDX_W-1:0]}];
    end

    // Woman rank memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_woman)
            r_rank_mem[{i_person, i_partner}] <= i_position;
        if (i_cmd.fetch) begin
            r_rank_suitor <= r_rank_mem[{r_choice, r_m}];
            r_rank_cur    <= r_rank_mem[{r_choice, cur_holder}];
        end
    end

    // Engagement flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_man_free    <= '1;
            r_woman_taken <= '0;
        end else if (i_cmd.start) begin
            r_man_free    <= '1;
            r_woman_taken <= '0;
        end else begin
            if (i_cmd.displace)
                r_man_free[r_cur] <= 1'b1;
            if (i_cmd.engage) begin
                r_man_free[r_m]         <= 1'b0;
                r_woman_taken[r_choice] <= 1'b1;
            end
        end
    end

    // Choice counters, partner indices and proposal registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n <= pop_clamped;
            for (int i = 0; i < MAX_PEOPLE; i++)
                r_next[i] <= '0;
        end
        if (i_cmd.search) begin
            r_m              <= cand_idx;
            r_next[cand_idx] <= r_next[cand_idx] + CNT_W'(1);
        end
        if (i_cmd.fetch)
            r_cur <= cur_holder;
        if (i_cmd.engage) begin
            r_man_wife[r_m]       <= r_choice;
            r_woman_man[r_choice] <= r_m;
        end
    end

    // Output register: advance one man per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_idx <= '0;
            r_out_last <= 1'b0;
        end else if (i_cmd.start) begin
            r_emit_idx <= '0;
        end else if (i_cmd.emit_load) begin
            r_out_man   <= r_emit_idx;
            r_out_woman <= r_man_free[r_emit_idx] ? '0 : r_man_wife[r_emit_idx];
            r_out_last  <= (({1'b0, r_emit_idx} + CNT_W'(1)) == r_n);
            r_emit_idx  <= r_emit_idx + IDX_W'(1);
        end
    end

    assign o_man_index   = r_out_man;
    assign o_woman_index = r_out_woman;
    assign o_last        = r_out_last;

endmodule

// ----- rtl/stable_matching_engine.sv -----
// Top level of the stable matching engine: controller plus datapath.
`timescale 1ns / 1ps

// Men-proposing stable matching over up to 16 men and 16 women. A load item
// (op 0 or 1) writes one preference entry. A run item (op 2) clears the
// matching state, then works one proposal at a time: search, then fetch when
// the chosen woman is free or outside the population, and search, fetch, then
// compare when her current holder must be compared, plus one final search
// that finds no free man with choices left; at most n*n proposals occur for
// population n. The proposal loop is bound by the single choice-memory read
// port and the registered rank reads.
// Afterwards one result per man, in man order, leaves through an output
// register at one per cycle while the consumer is ready; the input is not
// ready from the run transfer until the flagged last result is taken. A man
// left unmatched reports woman 0. The population register may be written any
// time the block is idle and is sampled at the start of each run.
module stable_matching_engine
    import smatch_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_op,
    input  logic [IDX_W-1:0] i_person,
    input  logic [IDX_W-1:0] i_position,
    input  logic [IDX_W-1:0] i_partner,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_man_index,
    output logic [IDX_W-1:0] o_woman_index,
    output logic             o_last
);

    t_cmd    cmd;
    t_status status;

    smatch_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    smatch_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_person      (i_person),
        .i_position    (i_position),
        .i_partner     (i_partner),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_man_index   (o_man_index),
        .o_woman_index (o_woman_index),
        .o_last        (o_last)
    );

endmodule
